@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the viewport transform block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/tvt_pkg.sv @@
// ---------------------------------------------------------------------------
// tvt_pkg
// Types, command codes and constants of the tile viewport transform.
// ---------------------------------------------------------------------------
package tvt_pkg;

    localparam int PAN_SHIFT = 4;   // a pan step is 16 pixels
    localparam int ZOOM_MIN  = 16;
    localparam int ZOOM_MAX  = 64;

    // Divider works on the magnitude of a 33-bit signed offset.
    localparam int DIV_WIDTH = 33;
    localparam int DIV_CNT_W = $clog2(DIV_WIDTH);

    localparam logic [2:0] CMD_PAN    = 3'd0;
    localparam logic [2:0] CMD_ZOOM   = 3'd1;
    localparam logic [2:0] CMD_RESIZE = 3'd2;
    localparam logic [2:0] CMD_JUMP   = 3'd3;
    localparam logic [2:0] CMD_MAP2SCR = 3'd4;
    localparam logic [2:0] CMD_SCR2MAP = 3'd5;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] arg_x;
        logic signed [15:0] arg_y;
    } tvt_req_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic [6:0]         tile_size;
    } tvt_rsp_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic mul_load;
        logic commit;
    } tvt_ctl_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } tvt_sts_t;

endpackage

@@ rtl/core/tvt_div.sv @@
// ---------------------------------------------------------------------------
// tvt_div
// Serial restoring divider: signed 33-bit dividend by a positive 7-bit
// divisor, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module tvt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tvt_pkg::DIV_WIDTH-1:0] dividend,
    input  logic [6:0]                    divisor,
    output logic                          done,
    output logic [31:0]                   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tvt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [tvt_pkg::DIV_WIDTH-1:0] quo_reg;
    logic [6:0]                    rem_reg;
    logic [6:0]                    dsr_reg;
    logic                          neg_reg;

    logic [tvt_pkg::DIV_WIDTH-1:0] magnitude;
    logic [7:0]                    partial;
    logic [8:0]                    diff;
    logic                          ge;
    logic [tvt_pkg::DIV_WIDTH-1:0] quo_signed;

    assign magnitude = dividend[tvt_pkg::DIV_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign partial   = {rem_reg, quo_reg[tvt_pkg::DIV_WIDTH-1]};
    assign diff      = {1'b0, partial} - {2'b00, dsr_reg};
    assign ge        = !diff[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tvt_pkg::DIV_CNT_W'(tvt_pkg::DIV_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[tvt_pkg::DIV_WIDTH-1];
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so seven bits hold it.
            rem_reg <= ge ? diff[6:0] : partial[6:0];
            quo_reg <= {quo_reg[tvt_pkg::DIV_WIDTH-2:0], ge};
        end
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[31:0];
    assign done       = done_reg;

endmodule

@@ rtl/core/tvt_ctrl.sv @@
// ---------------------------------------------------------------------------
// tvt_ctrl
// Sequencer of the viewport transform: capture, optional division,
// multiplication, commit and result strobe.
// ---------------------------------------------------------------------------
module tvt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output tvt_pkg::tvt_ctl_t ctl,
    input  tvt_pkg::tvt_sts_t sts
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = start ? S_PREP : S_IDLE;
            S_PREP:   state_next = sts.need_div ? S_DIV : S_MUL;
            S_DIV:    state_next = sts.div_done ? S_MUL : S_DIV;
            S_MUL:    state_next = S_COMMIT;
            S_COMMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_COMMIT);
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign ctl.capture   = (state_reg == S_IDLE) && start;
    assign ctl.div_start = (state_reg == S_PREP) && sts.need_div;
    assign ctl.mul_load  = (state_reg == S_MUL);
    assign ctl.commit    = (state_reg == S_COMMIT);

endmodule

@@ rtl/core/tvt_dp.sv @@
// ---------------------------------------------------------------------------
// tvt_dp
// Datapath of the viewport transform: viewport state, two divider lanes,
// two multiplier lanes and the result register.
// ---------------------------------------------------------------------------
module tvt_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  tvt_pkg::tvt_req_t request,
    input  tvt_pkg::tvt_ctl_t ctl,
    output tvt_pkg::tvt_sts_t sts,
    output tvt_pkg::tvt_rsp_t result
);

    tvt_pkg::tvt_req_t req_reg;
    tvt_pkg::tvt_rsp_t rsp_reg;
    tvt_pkg::tvt_rsp_t rsp_next;

    logic [31:0] anchor_x_reg;
    logic [31:0] anchor_y_reg;
    logic [15:0] half_w_reg;
    logic [15:0] half_h_reg;
    logic [6:0]  zoom_reg;
    logic [31:0] prod_x_reg;
    logic [31:0] prod_y_reg;

    logic [31:0] anchor_x_next;
    logic [31:0] anchor_y_next;
    logic [15:0] half_w_next;
    logic [15:0] half_h_next;
    logic [6:0]  zoom_next;

    logic                          is_zoom;
    logic signed [18:0]            zoom_sum;
    logic                          zoom_ok;
    logic [tvt_pkg::DIV_WIDTH-1:0] dividend_x;
    logic [tvt_pkg::DIV_WIDTH-1:0] dividend_y;
    logic                          done_x;
    logic                          done_y;
    logic [31:0]                   quo_x;
    logic [31:0]                   quo_y;
    logic signed [31:0]            mul_ax;
    logic signed [31:0]            mul_ay;
    logic signed [17:0]            mul_b;
    logic signed [49:0]            prod_x;
    logic signed [49:0]            prod_y;
    logic [15:0]                   hsum_x;
    logic [15:0]                   hsum_y;
    logic [15:0]                   hw;
    logic [15:0]                   hh;
    logic                          offset_ok;

    assign is_zoom  = (req_reg.command == tvt_pkg::CMD_ZOOM);
    assign zoom_sum = $signed({12'b0, zoom_reg}) + $signed({req_reg.arg_x, 2'b00});
    assign zoom_ok  = (zoom_sum >= 19'(tvt_pkg::ZOOM_MIN)) &&
                      (zoom_sum <= 19'(tvt_pkg::ZOOM_MAX));

    // Zoom divides the offset from anchor to screen centre; screen-to-map
    // divides the offset from anchor to the screen point.
    assign dividend_x = (is_zoom ? {{17{half_w_reg[15]}}, half_w_reg}
                                 : {{17{req_reg.arg_x[15]}}, req_reg.arg_x})
                        - {anchor_x_reg[31], anchor_x_reg};
    assign dividend_y = (is_zoom ? {{17{half_h_reg[15]}}, half_h_reg}
                                 : {{17{req_reg.arg_y[15]}}, req_reg.arg_y})
                        - {anchor_y_reg[31], anchor_y_reg};

    assign offset_ok    = !dividend_x[tvt_pkg::DIV_WIDTH-1] &&
                          !dividend_y[tvt_pkg::DIV_WIDTH-1];
    assign sts.need_div = (is_zoom && zoom_ok) ||
                          ((req_reg.command == tvt_pkg::CMD_SCR2MAP) && offset_ok);
    assign sts.div_done = done_x && done_y;

    tvt_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend_x),
        .divisor  (zoom_reg),
        .done     (done_x),
        .quotient (quo_x)
    );

    tvt_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend_y),
        .divisor  (zoom_reg),
        .done     (done_y),
        .quotient (quo_y)
    );

    // Zoom scales the quotient by the size change; jump and map-to-screen
    // scale the tile coordinate by the tile size. Only the low word is kept.
    assign mul_ax = is_zoom ? $signed(quo_x) : $signed({{16{req_reg.arg_x[15]}}, req_reg.arg_x});
    assign mul_ay = is_zoom ? $signed(quo_y) : $signed({{16{req_reg.arg_y[15]}}, req_reg.arg_y});
    assign mul_b  = is_zoom ? $signed({req_reg.arg_x, 2'b00}) : $signed({11'b0, zoom_reg});
    assign prod_x = mul_ax * mul_b;
    assign prod_y = mul_ay * mul_b;

    // The shift rounds down, so negative sizes are raised by one first; halving truncates toward zero.
    assign hsum_x = req_reg.arg_x + {15'b0, req_reg.arg_x[15]};
    assign hsum_y = req_reg.arg_y + {15'b0, req_reg.arg_y[15]};
    assign hw     = {hsum_x[15], hsum_x[15:1]};
    assign hh     = {hsum_y[15], hsum_y[15:1]};

    always_comb
    begin
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        half_w_next   = half_w_reg;
        half_h_next   = half_h_reg;
        zoom_next     = zoom_reg;
        rsp_next.ok   = 1'b1;
        rsp_next.result_x = '0;
        rsp_next.result_y = '0;
        case (req_reg.command)
            tvt_pkg::CMD_PAN:
            begin
                anchor_x_next = anchor_x_reg +
                    {{12{req_reg.arg_x[15]}}, req_reg.arg_x, 4'b0000};
                anchor_y_next = anchor_y_reg +
                    {{12{req_reg.arg_y[15]}}, req_reg.arg_y, 4'b0000};
            end
            tvt_pkg::CMD_ZOOM:
            begin
                if (zoom_ok)
                begin
                    anchor_x_next = anchor_x_reg - prod_x_reg;
                    anchor_y_next = anchor_y_reg - prod_y_reg;
                    zoom_next     = zoom_sum[6:0];
                end
                else
                begin
                    rsp_next.ok = 1'b0;
                end
            end
            tvt_pkg::CMD_RESIZE:
            begin
                anchor_x_next = anchor_x_reg + {{16{hw[15]}}, hw}
                                - {{16{half_w_reg[15]}}, half_w_reg};
                anchor_y_next = anchor_y_reg + {{16{hh[15]}}, hh}
                                - {{16{half_h_reg[15]}}, half_h_reg};
                half_w_next   = hw;
                half_h_next   = hh;
            end
            tvt_pkg::CMD_JUMP:
            begin
                anchor_x_next = {{16{half_w_reg[15]}}, half_w_reg} - prod_x_reg;
                anchor_y_next = {{16{half_h_reg[15]}}, half_h_reg} - prod_y_reg;
            end
            tvt_pkg::CMD_MAP2SCR:
            begin
                rsp_next.result_x = anchor_x_reg + prod_x_reg;
                rsp_next.result_y = anchor_y_reg + prod_y_reg;
            end
            tvt_pkg::CMD_SCR2MAP:
            begin
                rsp_next.ok = offset_ok;
                if (offset_ok)
                begin
                    rsp_next.result_x = quo_x;
                    rsp_next.result_y = quo_y;
                end
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
        if ((req_reg.command != tvt_pkg::CMD_MAP2SCR) &&
            (req_reg.command != tvt_pkg::CMD_SCR2MAP))
        begin
            rsp_next.result_x = anchor_x_next;
            rsp_next.result_y = anchor_y_next;
        end
        rsp_next.tile_size = zoom_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            half_w_reg   <= '0;
            half_h_reg   <= '0;
            zoom_reg     <= 7'(tvt_pkg::ZOOM_MAX);
        end
        else if (ctl.commit)
        begin
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            half_w_reg   <= half_w_next;
            half_h_reg   <= half_h_next;
            zoom_reg     <= zoom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= request;
        end
        if (ctl.mul_load)
        begin
            prod_x_reg <= prod_x[31:0];
            prod_y_reg <= prod_y[31:0];
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign result = rsp_reg;

endmodule

@@ rtl/core/tile_viewport_transform.sv @@
// ---------------------------------------------------------------------------
// tile_viewport_transform
// Tile-map viewport: pan, zoom, resize, jump and coordinate conversions.
// ---------------------------------------------------------------------------
//  Channel   Handshake       Payload
//  request   start / busy    tvt_req_t: command, arg_x, arg_y
//  result    done (strobe)   tvt_rsp_t: ok, result_x, result_y, tile_size
//
// A request is taken when start is high and busy is low; busy falls with the
// result strobe. A zoom within bounds or a screen-to-map with no negative
// offset runs a 33-step serial divider; every other request skips it. Reset
// sets the tile size to 64 and anchor and half sizes to 0, not the request or
// result registers. Done is high for one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_viewport_transform
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tvt_pkg::tvt_req_t request,
    output logic              done,
    output tvt_pkg::tvt_rsp_t result
);

    tvt_pkg::tvt_ctl_t ctl;
    tvt_pkg::tvt_sts_t sts;
    logic              tile_ok;

    tvt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .sts   (sts)
    );

    tvt_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .result  (result)
    );

    assign tile_ok = (result.tile_size >= 7'(tvt_pkg::ZOOM_MIN)) &&
                     (result.tile_size <= 7'(tvt_pkg::ZOOM_MAX)) &&
                     (result.tile_size[1:0] == 2'b00);

    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NXT(a_commit_done, clk, rst_n, ctl.commit, done)
    `ASSERT_IMP(a_tile_range, clk, rst_n, done, tile_ok)

endmodule
